// ===== rtl/core/hcfs_pkg.sv =====
`default_nettype none

package hcfs_pkg;

    localparam int RATE_BITS     = 16;
    localparam int STEP_BITS     = 15;
    localparam int MARGIN_BITS   = 16;
    localparam int OUT_BITS      = 23;
    localparam int MOVE_BITS     = 24;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int SINCE_BITS    = 4;

    localparam logic [OUT_BITS-1:0]    OUT_MAX            = {OUT_BITS{1'b1}};
    localparam logic [STEP_BITS-1:0]   MIN_STEP_RESET     = 15'd0;
    localparam logic [STEP_BITS-1:0]   INITIAL_STEP_RESET = 15'd1024;
    localparam logic [MARGIN_BITS-1:0] NOISE_MARGIN_RESET = 16'd33;
    localparam logic [SINCE_BITS-1:0]  SINCE_MAX          = {SINCE_BITS{1'b1}};
    localparam logic [SINCE_BITS-1:0]  SINCE_LONG         = 4'd3;

    localparam logic FUNC_STEP  = 1'b0;
    localparam logic FUNC_RESET = 1'b1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_STEP     = 2'd0,
        CFG_INITIAL_STEP = 2'd1,
        CFG_NOISE_MARGIN = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                 func;
        logic [RATE_BITS-1:0] sharpness;
        logic                 last_move_ok;
    } in_item_t;

    typedef struct packed {
        logic [OUT_BITS-1:0]         step_out;
        logic signed [MOVE_BITS-1:0] lens_move;
        logic                        below_min;
    } out_item_t;

    typedef struct packed {
        logic [STEP_BITS-1:0]   min_step;
        logic [STEP_BITS-1:0]   initial_step;
        logic [MARGIN_BITS-1:0] noise_margin;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/core/hcfs_cfg_regs.sv =====
`default_nettype none

module hcfs_cfg_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [hcfs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [hcfs_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output hcfs_pkg::cfg_t                            cfg
);

    hcfs_pkg::cfg_t cfg_reg;
    hcfs_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (hcfs_pkg::cfg_index_t'(cfg_index))
                hcfs_pkg::CFG_MIN_STEP:
                    cfg_next.min_step = cfg_data[hcfs_pkg::STEP_BITS-1:0];
                hcfs_pkg::CFG_INITIAL_STEP:
                    cfg_next.initial_step = cfg_data[hcfs_pkg::STEP_BITS-1:0];
                hcfs_pkg::CFG_NOISE_MARGIN:
                    cfg_next.noise_margin = cfg_data[hcfs_pkg::MARGIN_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_step     <= hcfs_pkg::MIN_STEP_RESET;
            cfg_reg.initial_step <= hcfs_pkg::INITIAL_STEP_RESET;
            cfg_reg.noise_margin <= hcfs_pkg::NOISE_MARGIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hcfs_step_rule.sv =====
`default_nettype none

module hcfs_step_rule #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hcfs_pkg::cfg_t     cfg,
    input  wire hcfs_pkg::in_item_t item,
    input  wire logic               fire,
    output hcfs_pkg::out_item_t     result
);

    localparam int SB = hcfs_pkg::STEP_BITS;
    localparam int RB = hcfs_pkg::RATE_BITS;
    localparam int OB = OFFSET_BITS;
    localparam int DW = (OB - 1 > hcfs_pkg::OUT_BITS) ? OB - 1 : hcfs_pkg::OUT_BITS;
    localparam logic signed [OB:0] OFF_LIM = {2'b00, {(OB-1){1'b1}}};
    localparam logic signed [OB:0] OFF_NEG = -OFF_LIM;

    logic [SB-1:0]                   step_reg, step_next;
    logic                            far_reg, far_next;
    logic [hcfs_pkg::SINCE_BITS-1:0] since_reg, since_next;
    logic signed [OB-1:0]            off_reg, off_next;
    logic [RB-1:0]                   prev_reg, prev_next;
    logic [RB-1:0]                   best_reg, best_next;

    logic [hcfs_pkg::SINCE_BITS-1:0] since_u;
    logic signed [OB-1:0]            off_u;
    logic [RB-1:0]                   best_u;
    logic [RB:0]                     rate_pe;
    logic                            improve, low, fall, near_best, fine, ret;
    logic [SB+1:0]                   step3;
    logic [SB-1:0]                   step_q;
    logic signed [OB:0]              off_sum;
    logic signed [OB-1:0]            off_sat;
    logic [OB-2:0]                   back_mag;
    logic [DW-1:0]                   reach;
    logic [hcfs_pkg::OUT_BITS-1:0]   s_val, mag;
    logic [hcfs_pkg::MOVE_BITS-1:0]  mag_ext;
    logic                            dir;

    always_comb
    begin
        since_u = (since_reg == hcfs_pkg::SINCE_MAX) ? since_reg : since_reg + 1'b1;
        improve = {1'b0, item.sharpness} >= ({1'b0, best_reg} + {1'b0, cfg.noise_margin});
        off_u   = improve ? '0 : off_reg;
        best_u  = improve ? item.sharpness : best_reg;
        since_u = improve ? '0 : since_u;

        rate_pe   = {1'b0, item.sharpness} + {1'b0, cfg.noise_margin};
        low       = item.sharpness < cfg.noise_margin;
        fall      = rate_pe < {1'b0, prev_reg};
        near_best = rate_pe < {1'b0, best_u};
        fine      = ({1'b0, step_reg, 1'b0} < ({2'b00, cfg.min_step} + {1'b0, cfg.min_step, 1'b0}))
                    && (off_u > $signed({{(OB-SB){1'b0}}, step_reg}));
        ret       = item.last_move_ok && !low && !fall && near_best
                    && ((since_u > hcfs_pkg::SINCE_LONG) || fine);

        step3  = {2'b00, step_reg} + {1'b0, step_reg, 1'b0};
        step_q = step3[SB+1:2];

        far_next   = far_reg;
        step_next  = step_reg;
        since_next = since_u;
        if (!item.last_move_ok)
        begin
            far_next   = !far_reg;
            step_next  = step_reg >> 1;
            since_next = '0;
        end
        else if (low)
        begin
            step_next = cfg.initial_step;
        end
        else if (fall)
        begin
            far_next   = !far_reg;
            step_next  = step_q;
            since_next = '0;
        end
        else if (ret)
        begin
            far_next   = !off_u[OB-1];
            step_next  = step_q;
            since_next = '0;
        end

        off_sum = far_next ? ({off_u[OB-1], off_u} - $signed({{(OB+1-SB){1'b0}}, step_next}))
                           : ({off_u[OB-1], off_u} + $signed({{(OB+1-SB){1'b0}}, step_next}));
        if (off_sum > OFF_LIM)
            off_sat = OFF_LIM[OB-1:0];
        else if (off_sum < OFF_NEG)
            off_sat = OFF_NEG[OB-1:0];
        else
            off_sat = off_sum[OB-1:0];

        off_next  = ret ? '0 : off_sat;
        prev_next = item.sharpness;
        best_next = best_u;

        back_mag = off_u[OB-1] ? (~off_u[OB-2:0] + 1'b1) : off_u[OB-2:0];
        reach    = ret ? DW'(back_mag) : DW'(step_next);
        s_val    = (reach > DW'(hcfs_pkg::OUT_MAX)) ? hcfs_pkg::OUT_MAX
                                                    : reach[hcfs_pkg::OUT_BITS-1:0];
        mag      = (s_val > hcfs_pkg::OUT_BITS'(cfg.min_step)) ? s_val
                                                               : hcfs_pkg::OUT_BITS'(cfg.min_step);
        mag_ext  = {1'b0, mag};
        dir      = far_next;

        result.step_out  = s_val;
        result.lens_move = dir ? $signed(mag_ext) : $signed(-mag_ext);
        result.below_min = s_val < hcfs_pkg::OUT_BITS'(cfg.min_step);

        if (item.func == hcfs_pkg::FUNC_RESET)
        begin
            far_next   = 1'b1;
            step_next  = cfg.initial_step;
            since_next = '0;
            off_next   = '0;
            prev_next  = '0;
            best_next  = '0;
            result     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= hcfs_pkg::INITIAL_STEP_RESET;
            far_reg   <= 1'b1;
            since_reg <= '0;
            off_reg   <= '0;
            prev_reg  <= '0;
            best_reg  <= '0;
        end
        else if (fire)
        begin
            step_reg  <= step_next;
            far_reg   <= far_next;
            since_reg <= since_next;
            off_reg   <= off_next;
            prev_reg  <= prev_next;
            best_reg  <= best_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hill_climb_focus_stepper.sv =====
`default_nettype none

// Contrast autofocus step controller: every input transfer (one frame's sharpness and the
// outcome of the previous lens move) yields exactly one result transfer with the step size,
// the signed lens move and a below-minimum flag. Items pass through an input register and a
// result register with the step rule between them, so one item is taken every clock cycle
// while the output is not stalled, and its result is offered from the result register. The search
// state advances only as an item moves into the result register, so consecutive items see each
// other's updates in order. Configuration writes must only be made while the block is empty.
module hill_climb_focus_stepper #(
    parameter int OFFSET_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [hcfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [hcfs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire hcfs_pkg::in_item_t                 in_data,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output hcfs_pkg::out_item_t                     out_data
);

    hcfs_pkg::cfg_t      cfg;
    hcfs_pkg::in_item_t  in_data_reg;
    hcfs_pkg::out_item_t out_data_reg;
    hcfs_pkg::out_item_t result;
    logic                in_valid_reg, in_valid_next;
    logic                out_valid_reg, out_valid_next;
    logic                advance, fire, take;

    hcfs_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hcfs_step_rule #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_step_rule (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (in_data_reg),
        .fire   (fire),
        .result (result)
    );

    always_comb
    begin
        advance        = !out_valid_reg || !out_stall;
        fire           = in_valid_reg && advance;
        in_stall       = in_valid_reg && !advance;
        take           = in_valid && !in_stall;
        in_valid_next  = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= in_data;
        end
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/hcfs_checker.sv =====
`default_nettype none

module hcfs_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_stall,
    input  wire logic                out_valid,
    input  wire logic                out_stall,
    input  wire hcfs_pkg::out_item_t out_data
);

    logic signed [hcfs_pkg::MOVE_BITS-1:0] step_pos;

    assign step_pos = $signed({1'b0, out_data.step_out});

    // A stalled result transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The input side only stalls when both registers are full.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with room downstream");

    // Without the minimum-step clamp the move is the step, signed by direction.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.below_min |->
            (out_data.lens_move == step_pos) || (out_data.lens_move == -step_pos))
        else $error("lens move does not match step");

    // A clamped move is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.below_min |-> out_data.lens_move != '0)
        else $error("clamped lens move is zero");

endmodule

bind hill_climb_focus_stepper hcfs_checker u_hcfs_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int OFFSET_BITS = 24;

    class focus_scoreboard;

        logic [hcfs_pkg::STEP_BITS-1:0]   floor_step;
        logic [hcfs_pkg::STEP_BITS-1:0]   restart_step;
        logic [hcfs_pkg::MARGIN_BITS-1:0] margin;

        logic [hcfs_pkg::STEP_BITS-1:0]   stride;
        bit                               heading_far;
        logic [hcfs_pkg::SINCE_BITS-1:0]  steps_since_turn;
        longint                           back_offset;
        longint                           last_rate;
        longint                           peak_rate;

        longint                           offset_cap;
        hcfs_pkg::out_item_t              expected_moves[$];
        int                               errors;
        int                               results_seen;

        function new(longint cap);
            offset_cap   = cap;
            floor_step   = hcfs_pkg::MIN_STEP_RESET;
            restart_step = hcfs_pkg::INITIAL_STEP_RESET;
            margin       = hcfs_pkg::NOISE_MARGIN_RESET;
            errors       = 0;
            results_seen = 0;
            restart();
        endfunction

        function void restart();
            stride           = restart_step;
            heading_far      = 1'b1;
            steps_since_turn = '0;
            back_offset      = 0;
            last_rate        = 0;
            peak_rate        = 0;
        endfunction

        function void set_register(hcfs_pkg::cfg_index_t idx,
                                   logic [hcfs_pkg::CFG_DATA_BITS-1:0] val);
            case (idx)
                hcfs_pkg::CFG_MIN_STEP:     floor_step = val[hcfs_pkg::STEP_BITS-1:0];
                hcfs_pkg::CFG_INITIAL_STEP: restart_step = val[hcfs_pkg::STEP_BITS-1:0];
                hcfs_pkg::CFG_NOISE_MARGIN: margin = val[hcfs_pkg::MARGIN_BITS-1:0];
                default:                    ;
            endcase
        endfunction

        function int pending();
            return expected_moves.size();
        endfunction

        function hcfs_pkg::out_item_t move_for(longint distance);
            hcfs_pkg::out_item_t res;
            longint              capped;
            longint              mag;
            longint              signed_mag;
            longint              out_cap;
            out_cap    = hcfs_pkg::OUT_MAX;
            capped     = (distance > out_cap) ? out_cap : distance;
            mag        = (capped > longint'(floor_step)) ? capped : longint'(floor_step);
            signed_mag = heading_far ? mag : -mag;
            res.step_out  = capped[hcfs_pkg::OUT_BITS-1:0];
            res.lens_move = signed_mag[hcfs_pkg::MOVE_BITS-1:0];
            res.below_min = (capped < longint'(floor_step));
            return res;
        endfunction

        function void note_frame(hcfs_pkg::in_item_t frame);
            longint rate;
            longint eps;
            longint back;
            rate = frame.sharpness;
            eps  = margin;
            if (frame.func == hcfs_pkg::FUNC_RESET)
            begin
                restart();
                expected_moves.push_back('0);
                return;
            end
            if (steps_since_turn < hcfs_pkg::SINCE_MAX)
                steps_since_turn = steps_since_turn + 1'b1;
            if (rate >= peak_rate + eps)
            begin
                back_offset      = 0;
                peak_rate        = rate;
                steps_since_turn = '0;
            end
            if (!frame.last_move_ok)
            begin
                heading_far      = !heading_far;
                steps_since_turn = '0;
                stride           = stride >> 1;
            end
            else if (rate < eps)
            begin
                stride = restart_step;
            end
            else if (rate + eps < last_rate)
            begin
                heading_far      = !heading_far;
                stride           = hcfs_pkg::STEP_BITS'((longint'(stride) * 3) >> 2);
                steps_since_turn = '0;
            end
            else if (rate + eps < peak_rate &&
                     (steps_since_turn > hcfs_pkg::SINCE_LONG ||
                      (longint'(stride) * 2 < longint'(floor_step) * 3 &&
                       back_offset > longint'(stride))))
            begin
                back             = (back_offset < 0) ? -back_offset : back_offset;
                heading_far      = (back_offset >= 0);
                stride           = hcfs_pkg::STEP_BITS'((longint'(stride) * 3) >> 2);
                back_offset      = 0;
                steps_since_turn = '0;
                last_rate        = rate;
                expected_moves.push_back(move_for(back));
                return;
            end
            last_rate   = rate;
            back_offset = back_offset + (heading_far ? -longint'(stride) : longint'(stride));
            if (back_offset > offset_cap)
                back_offset = offset_cap;
            if (back_offset < -offset_cap)
                back_offset = -offset_cap;
            expected_moves.push_back(move_for(longint'(stride)));
        endfunction

        task report_mismatch(string what, longint got_v, longint want_v);
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     results_seen, what, got_v, want_v);
            errors++;
        endtask

        task check_move(hcfs_pkg::out_item_t got);
            hcfs_pkg::out_item_t want;
            if (expected_moves.size() == 0)
            begin
                report_mismatch("unexpected result, step_out", got.step_out, 0);
                return;
            end
            want = expected_moves.pop_front();
            if (got.step_out !== want.step_out)
                report_mismatch("step_out", got.step_out, want.step_out);
            if (got.lens_move !== want.lens_move)
                report_mismatch("lens_move", got.lens_move, want.lens_move);
            if (got.below_min !== want.below_min)
                report_mismatch("below_min", got.below_min, want.below_min);
            results_seen++;
        endtask

    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [hcfs_pkg::CFG_IDX_BITS-1:0]  cfg_index = hcfs_pkg::CFG_MIN_STEP;
    logic [hcfs_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    hcfs_pkg::in_item_t                 in_data = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    hcfs_pkg::out_item_t                out_data;

    focus_scoreboard sb;
    bit              quiet = 1'b0;
    int              hold_cycles = 0;
    int              stall_left = 0;
    int              margin_now = hcfs_pkg::NOISE_MARGIN_RESET;

    hill_climb_focus_stepper #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function int fit_rate(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    function bit mostly_ok();
        return ($urandom_range(0, 19) != 0);
    endfunction

    task offer_frame(logic func, int rate, bit ok);
        hcfs_pkg::in_item_t frame;
        int                 gap;
        frame.func         = func;
        frame.sharpness    = hcfs_pkg::RATE_BITS'(fit_rate(rate));
        frame.last_move_ok = ok;
        gap = quiet ? 0 : idle_span();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= frame;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_frame(frame);
    endtask

    task wait_drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(hcfs_pkg::cfg_index_t idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[hcfs_pkg::CFG_DATA_BITS-1:0];
        @(posedge clk);
        sb.set_register(idx, val[hcfs_pkg::CFG_DATA_BITS-1:0]);
    endtask

    task configure(int phase);
        int floor_v;
        int restart_v;
        int margin_v;
        case (phase)
            0:
            begin
                floor_v   = 0;
                restart_v = 1;
                margin_v  = 0;
            end
            1:
            begin
                floor_v   = 32767;
                restart_v = 32767;
                margin_v  = 65535;
            end
            2:
            begin
                floor_v   = 32767;
                restart_v = 32767;
                margin_v  = 100;
            end
            default:
            begin
                floor_v   = $urandom_range(0, 1) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 300);
                restart_v = $urandom_range(0, 1) ? $urandom_range(1, 2000)
                                                 : $urandom_range(1, 32767);
                margin_v  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 500);
            end
        endcase
        write_reg(hcfs_pkg::CFG_MIN_STEP, floor_v);
        write_reg(hcfs_pkg::CFG_INITIAL_STEP, restart_v);
        write_reg(hcfs_pkg::CFG_NOISE_MARGIN, margin_v);
        cfg_we <= 1'b0;
        margin_now = margin_v;
    endtask

    task random_frames(int count);
        int done;
        int kind;
        int level;
        int n;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
            begin
                level = $urandom_range(0, 20000);
                n = $urandom_range(2, 12);
                repeat (n)
                begin
                    level = fit_rate(level + $urandom_range(0, 4000));
                    offer_frame(hcfs_pkg::FUNC_STEP, level, mostly_ok());
                end
                done += n;
                n = $urandom_range(1, 6);
                repeat (n)
                begin
                    level = fit_rate(level - $urandom_range(0, 3000));
                    offer_frame(hcfs_pkg::FUNC_STEP, level, mostly_ok());
                end
                done += n;
                n = $urandom_range(0, 8);
                repeat (n)
                    offer_frame(hcfs_pkg::FUNC_STEP,
                                level - $urandom_range(0, 2 * margin_now + 1),
                                mostly_ok());
                done += n;
            end
            else if (kind < 60)
            begin
                level = $urandom_range(0, 65535);
                n = $urandom_range(5, 40);
                repeat (n)
                    offer_frame(hcfs_pkg::FUNC_STEP,
                                level - margin_now / 2 + $urandom_range(0, margin_now),
                                mostly_ok());
                done += n;
            end
            else if (kind < 72)
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    offer_frame(hcfs_pkg::FUNC_STEP, $urandom_range(0, margin_now),
                                mostly_ok());
                done += n;
            end
            else if (kind < 95)
            begin
                n = $urandom_range(1, 10);
                repeat (n)
                    offer_frame(($urandom_range(0, 9) == 0) ? hcfs_pkg::FUNC_RESET
                                                            : hcfs_pkg::FUNC_STEP,
                                $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
                done += n;
            end
            else
            begin
                offer_frame(hcfs_pkg::FUNC_RESET, $urandom_range(0, 65535),
                            1'($urandom_range(0, 1)));
                done += 1;
            end
        end
    endtask

    initial
    begin : result_side
        int n;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_move(out_data);
            if (hold_cycles > 0)
            begin
                stall_left  = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                n = quiet ? 0 : idle_span();
                if (n == 0)
                    out_stall <= 1'b0;
                else
                begin
                    out_stall  <= 1'b1;
                    stall_left = n - 1;
                end
            end
        end
    end

    initial
    begin : stimulus
        sb = new((longint'(1) << (OFFSET_BITS - 1)) - 1);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_frame(hcfs_pkg::FUNC_RESET, 65535, 1'b0);
        offer_frame(hcfs_pkg::FUNC_STEP, 0, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 32, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 33, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 2000, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 8000, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 20000, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 65535, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 65535, 1'b0);
        offer_frame(hcfs_pkg::FUNC_STEP, 30000, 1'b1);
        repeat (5) offer_frame(hcfs_pkg::FUNC_STEP, 30000, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 30010, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 0, 1'b0);
        offer_frame(hcfs_pkg::FUNC_STEP, 65535, 1'b1);
        offer_frame(hcfs_pkg::FUNC_RESET, 0, 1'b1);
        offer_frame(hcfs_pkg::FUNC_STEP, 1000, 1'b1);

        for (int phase = 0; phase < 8; phase++)
        begin
            wait_drain();
            quiet = (phase % 3 == 2);
            configure(phase);
            offer_frame(hcfs_pkg::FUNC_RESET, $urandom_range(0, 65535),
                        1'($urandom_range(0, 1)));
            if (phase == 2)
            begin
                repeat (270) offer_frame(hcfs_pkg::FUNC_STEP, 40000, 1'b1);
                repeat (5) offer_frame(hcfs_pkg::FUNC_STEP, 39000, 1'b1);
                repeat (10) offer_frame(hcfs_pkg::FUNC_STEP, 40050, 1'b1);
            end
            if (phase == 4)
                hold_cycles = 150;
            random_frames(180);
        end

        quiet = 1'b1;
        wait_drain();
        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch("results still outstanding", sb.pending(), 0);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #6000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
